FILE: rtl/mfrb_pkg.sv
package mfrb_pkg;

    // Store geometry
    localparam int STORE_BYTES = 4096;
    localparam int MAGIC_BYTES = 4;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int SIZE_W      = 13;
    localparam int SUM_W       = SIZE_W + 1;
    localparam int MAGIC_W     = 8 * MAGIC_BYTES;
    localparam int BYTE_W      = 8;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int MIDX_W      = $clog2(MAGIC_BYTES);

    localparam logic [SIZE_W-1:0] CFG_RESET = SIZE_W'(4096);
    localparam logic [SIZE_W-1:0] RING_MAX  = SIZE_W'(STORE_BYTES);

    // Stream packing
    localparam int IN_DATA_BITS  = SIZE_W + MAGIC_W + 2 * ADDR_W + BYTE_W;
    localparam int IN_DATA_W     = ((IN_DATA_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = STATUS_W + ADDR_W + BYTE_W;
    localparam int OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;

    // Command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    typedef enum logic [FUNC_W-1:0] {
        FN_BEGIN = 2'd0,
        FN_PUT   = 2'd1,
        FN_CHECK = 2'd2,
        FN_READ  = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_TOO_LARGE  = 3'd1,
        ST_OOB        = 3'd2,
        ST_MAGIC_BAD  = 3'd3,
        ST_NO_PAYLOAD = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        K_BEGIN     = 3'd0,
        K_REJECT    = 3'd1,
        K_PUT       = 3'd2,
        K_CHECK     = 3'd3,
        K_CHECK_OOB = 3'd4,
        K_READ      = 3'd5,
        K_READ_OOB  = 3'd6
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [SIZE_W-1:0]    size;
        logic [SIZE_W-1:0]    total;
        logic [MAGIC_W-1:0]   magic;
        logic [ADDR_W-1:0]    addr_a;
        logic [ADDR_W-1:0]    addr_b;
        logic [BYTE_W-1:0]    pbyte;
    } cmd_t;

    typedef struct packed {
        status_t              status;
        logic [ADDR_W-1:0]    offset;
        logic [BYTE_W-1:0]    rbyte;
    } result_t;

    // Big-endian byte k of a magic word
    function automatic logic [BYTE_W-1:0] magic_byte(input logic [MAGIC_W-1:0] m,
                                                     input logic [MIDX_W-1:0] k);
        logic [BYTE_W-1:0] b;
        b = m[MAGIC_W-1 -: BYTE_W];
        case (k)
            2'd0:    b = m[31:24];
            2'd1:    b = m[23:16];
            2'd2:    b = m[15:8];
            default: b = m[7:0];
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/mfrb_ram.sv
module mfrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/mfrb_front.sv
module mfrb_front
    import mfrb_pkg::*;
(
    input  logic [IN_DATA_W-1:0] tdata,
    input  logic [FUNC_W-1:0]    tuser,
    input  logic [SIZE_W-1:0]    ring,
    output cmd_t                 cmd
);

    logic [SIZE_W-1:0]  size;
    logic [MAGIC_W-1:0] magic;
    logic [ADDR_W-1:0]  roff;
    logic [ADDR_W-1:0]  bidx;
    logic [SUM_W-1:0]   total;
    logic [SUM_W-1:0]   chk_end;
    logic [SUM_W-1:0]   end_magic;
    logic [SUM_W-1:0]   pos;
    logic [SUM_W-1:0]   ring_x;

    assign size  = tdata[SIZE_W-1:0];
    assign magic = tdata[SIZE_W +: MAGIC_W];
    assign roff  = tdata[SIZE_W + MAGIC_W +: ADDR_W];
    assign bidx  = tdata[SIZE_W + MAGIC_W + ADDR_W +: ADDR_W];

    assign ring_x    = SUM_W'(ring);
    assign total     = SUM_W'(size) + SUM_W'(2 * MAGIC_BYTES);
    assign end_magic = SUM_W'(roff) + SUM_W'(MAGIC_BYTES) + SUM_W'(size);
    assign chk_end   = end_magic + SUM_W'(MAGIC_BYTES);
    assign pos       = SUM_W'(roff) + SUM_W'(MAGIC_BYTES) + SUM_W'(bidx);

    always_comb
    begin
        cmd.size   = size;
        cmd.total  = total[SIZE_W-1:0];
        cmd.magic  = magic;
        cmd.addr_a = roff;
        cmd.addr_b = end_magic[ADDR_W-1:0];
        cmd.pbyte  = tdata[SIZE_W + MAGIC_W + 2 * ADDR_W +: BYTE_W];
        cmd.kind   = K_PUT;
        unique case (func_t'(tuser))
            FN_BEGIN: cmd.kind = (total > ring_x) ? K_REJECT : K_BEGIN;
            FN_PUT:   cmd.kind = K_PUT;
            FN_CHECK: cmd.kind = (chk_end > ring_x) ? K_CHECK_OOB : K_CHECK;
            FN_READ:
            begin
                cmd.kind   = (pos >= ring_x) ? K_READ_OOB : K_READ;
                cmd.addr_a = pos[ADDR_W-1:0];
            end
            default:  cmd.kind = K_PUT;
        endcase
    end

endmodule

FILE: rtl/mfrb_queue.sv
module mfrb_queue
    import mfrb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);

    cmd_t              entry_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == QCNT_W'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full) else $error("queue push while full");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(Q_DEPTH)) else $error("queue count out of range");
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not drop on pop");

endmodule

FILE: rtl/mfrb_back.sv
module mfrb_back
    import mfrb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SIZE_W-1:0] ring,
    input  logic              q_empty,
    input  cmd_t              q_head,
    output logic              q_pop,
    output logic              clear_done,
    output logic              out_valid,
    input  logic              out_ready,
    output result_t           out_res
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_FILL  = 6'b000100,
        S_MAGIC = 6'b001000,
        S_CHECK = 6'b010000,
        S_READ  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              cur_reg, cur_next;
    logic [SIZE_W-1:0] wo_reg, wo_next;
    logic [SIZE_W-1:0] pp_reg, pp_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [ADDR_W-1:0] endp_reg, endp_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic              mis_reg, mis_next;
    logic              out_valid_reg, out_valid_next;
    result_t           res_reg, res_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    logic              out_free;
    logic [SIZE_W-1:0] free_tail;
    logic [3:0]        cnt_m1;
    logic              mm;

    mfrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free   = !out_valid_reg || out_ready;
    assign clear_done = (state_reg != S_CLEAR);
    assign out_valid  = out_valid_reg;
    assign out_res    = res_reg;
    assign free_tail  = (wo_reg < ring) ? ring - wo_reg : '0;
    assign cnt_m1     = cnt_reg - 1'b1;
    assign mm         = (ram_rdata != magic_byte(cur_reg.magic, cnt_m1[MIDX_W-1:0]));

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        wo_next        = wo_reg;
        pp_next        = pp_reg;
        rem_next       = rem_reg;
        addr_next      = addr_reg;
        base_next      = base_reg;
        endp_next      = endp_reg;
        cnt_next       = cnt_reg;
        mis_next       = mis_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_next       = res_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = '0;
        ram_raddr      = q_head.addr_a;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
                if (addr_reg == ADDR_W'(STORE_BYTES - 1))
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (!q_empty && out_free)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_head;
                    cnt_next = '0;
                    mis_next = 1'b0;
                    res_next = '{status: ST_OK, offset: '0, rbyte: '0};
                    unique case (q_head.kind) inside
                        K_REJECT:
                        begin
                            res_next.status = ST_TOO_LARGE;
                            out_valid_next  = 1'b1;
                        end
                        K_CHECK_OOB, K_READ_OOB:
                        begin
                            res_next.status = ST_OOB;
                            out_valid_next  = 1'b1;
                        end
                        K_PUT:
                        begin
                            if (rem_reg == '0)
                            begin
                                res_next.status = ST_NO_PAYLOAD;
                            end
                            else
                            begin
                                ram_we    = (pp_reg < RING_MAX);
                                ram_waddr = pp_reg[ADDR_W-1:0];
                                ram_wdata = q_head.pbyte;
                                pp_next   = pp_reg + 1'b1;
                                rem_next  = rem_reg - 1'b1;
                            end
                            out_valid_next = 1'b1;
                        end
                        K_BEGIN:
                        begin
                            if (q_head.total > free_tail && free_tail != '0)
                            begin
                                // Record misses the tail: zero it first
                                addr_next  = wo_reg[ADDR_W-1:0];
                                state_next = S_FILL;
                            end
                            else
                            begin
                                base_next = (q_head.total > free_tail) ? '0
                                                                       : wo_reg[ADDR_W-1:0];
                                endp_next = ADDR_W'(SUM_W'(base_next) + SUM_W'(MAGIC_BYTES)
                                                    + SUM_W'(q_head.size));
                                state_next = S_MAGIC;
                            end
                        end
                        K_CHECK:
                        begin
                            state_next = S_CHECK;
                        end
                        K_READ:
                        begin
                            ram_raddr  = q_head.addr_a;
                            state_next = S_READ;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            S_FILL:
            begin
                ram_we = 1'b1;
                if ({1'b0, addr_reg} == ring - 1'b1)
                begin
                    base_next  = '0;
                    endp_next  = ADDR_W'(SUM_W'(MAGIC_BYTES) + SUM_W'(cur_reg.size));
                    state_next = S_MAGIC;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end

            S_MAGIC:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[MIDX_W] ? endp_reg + ADDR_W'(cnt_reg[MIDX_W-1:0])
                                            : base_reg + ADDR_W'(cnt_reg[MIDX_W-1:0]);
                ram_wdata = magic_byte(cur_reg.magic, cnt_reg[MIDX_W-1:0]);
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == 4'(2 * MAGIC_BYTES - 1))
                begin
                    wo_next        = SIZE_W'(endp_reg) + SIZE_W'(MAGIC_BYTES);
                    pp_next        = SIZE_W'(base_reg) + SIZE_W'(MAGIC_BYTES);
                    rem_next       = cur_reg.size;
                    res_next       = '{status: ST_OK, offset: base_reg, rbyte: '0};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_CHECK:
            begin
                ram_raddr = cnt_reg[MIDX_W] ? cur_reg.addr_b + ADDR_W'(cnt_reg[MIDX_W-1:0])
                                            : cur_reg.addr_a + ADDR_W'(cnt_reg[MIDX_W-1:0]);
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg != '0)
                begin
                    mis_next = mis_reg || mm;
                end
                if (cnt_reg == 4'(2 * MAGIC_BYTES))
                begin
                    res_next.status = (mis_reg || mm) ? ST_MAGIC_BAD : ST_OK;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_READ:
            begin
                res_next.rbyte = ram_rdata;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            wo_reg        <= '0;
            pp_reg        <= '0;
            rem_reg       <= '0;
            addr_reg      <= '0;
            cnt_reg       <= '0;
            mis_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wo_reg        <= wo_next;
            pp_reg        <= pp_next;
            rem_reg       <= rem_next;
            addr_reg      <= addr_next;
            cnt_reg       <= cnt_next;
            mis_reg       <= mis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        base_reg <= base_next;
        endp_reg <= endp_next;
        res_reg  <= res_next;
    end

    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !q_pop) else $error("item taken during clear");
    a_busy_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL || state_reg == S_MAGIC || state_reg == S_CHECK
         || state_reg == S_READ) |-> !out_valid_reg)
        else $error("result pending during a long operation");
    a_payload_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        (SUM_W'(pp_reg) + SUM_W'(rem_reg)) <= SUM_W'(STORE_BYTES))
        else $error("payload reservation runs past the store");
    a_wo_range: assert property (@(posedge clk) disable iff (!rst_n)
        wo_reg <= RING_MAX) else $error("write offset past the store");

endmodule

FILE: rtl/magic_framed_record_ring_buffer.sv
// A payload byte, a rejected item or an out-of-bounds check or read is answered
// from the idle state; a read byte goes through the read state, a read check the
// check state and a begin write the magic state, after zeroing any tail it skips.
// Throughput: one payload byte or rejected item per cycle while the result
// output is not held; a read byte, a read check or a begin holds the back end
// busy, a begin also for any tail clear.
// Reset: a clearing pass zeroes the store; s_axis_tready stays low meanwhile,
// while configuration writes are taken at any time.
module magic_framed_record_ring_buffer
    import mfrb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Configuration: buffer_bytes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [SIZE_W-1:0]     cfg_data,

    // Input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: record_size[12:0], record_magic[44:13], record_offset[56:45],
    //        byte_index[68:57], payload_byte[76:69], zero pad[79:77]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: func[1:0]
    input  logic [FUNC_W-1:0]     s_axis_tuser,

    // Result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: status[2:0], offset_out[14:3], read_byte[22:15], zero pad[23]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [SIZE_W-1:0] buffer_bytes_reg;
    logic [SIZE_W-1:0] buffer_bytes_next;
    logic [SIZE_W-1:0] ring;
    cmd_t              front_cmd;
    cmd_t              q_head;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    logic              clear_done;
    result_t           res;

    // Configuration is always taken; the user must write it only while idle (not enforced)
    assign cfg_ready         = 1'b1;
    assign buffer_bytes_next = (cfg_valid && cfg_ready) ? cfg_data : buffer_bytes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_bytes_reg <= CFG_RESET;
        end
        else
        begin
            buffer_bytes_reg <= buffer_bytes_next;
        end
    end

    // Clamp the ring to the physical store
    assign ring = (buffer_bytes_reg > RING_MAX) ? RING_MAX : buffer_bytes_reg;

    // Front: decode the item and settle every check that needs no stored state
    mfrb_front u_front (
        .tdata (s_axis_tdata),
        .tuser (s_axis_tuser),
        .ring  (ring),
        .cmd   (front_cmd)
    );

    // Hold items off until the store has been cleared and the queue has room
    assign s_axis_tready = clear_done && !q_full;

    // Short command queue so the front keeps taking items while the back stalls
    mfrb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (s_axis_tvalid && s_axis_tready),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    // Back: owns the byte store, the write state and the result register
    mfrb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .ring       (ring),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .clear_done (clear_done),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_res    (res)
    );

    // Pack the result, status in the lowest bits
    assign m_axis_tdata = OUT_DATA_W'({res.rbyte, res.offset, res.status});

endmodule
